### hdl/matrix_multiply_accumulate_assert.svh
// ----------------------------------------------------------------------------
// matrix multiply-accumulate assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH

// same-cycle implication, off during reset
`define MMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// types and fixed widths shared by the matrix multiply-accumulate modules
// ----------------------------------------------------------------------------
package mma_pkg;

  // fixed field widths
  localparam int IDX_W = 3;
  localparam int DIM_W = 4;
  localparam int VAL_W = 32;
  localparam int REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS     = 2'd2;

  // request codes
  typedef enum logic [1:0] {
    REQ_WR_A    = 2'd0,
    REQ_WR_B    = 2'd1,
    REQ_WR_C    = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_RESULT = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ISSUE = 2'd1,
    S_DRAIN = 2'd2
  } state_t;

  // command word from controller to datapath
  typedef struct packed {
    logic             wr_en;
    req_t             sel;
    logic             ack;
    status_t          ack_status;
    logic             mac;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] kk;
  } mma_cmd_t;

  // register value to working dimension: zero acts as one, clamp at max
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] r,
                                               logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] d;
    d = r;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > max_dim) begin
      d = max_dim;
    end
    return d;
  endfunction

endpackage

### hdl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// request decode, dimension registers and the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module mma_ctrl import mma_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           req_type,
  input  logic [IDX_W-1:0]     row,
  input  logic [IDX_W-1:0]     col,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [DIM_W-1:0]     wr_data,
  input  logic                 run_done,
  output logic                 busy,
  output mma_cmd_t             cmd
);

  localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

  state_t           state, state_next;
  logic [DIM_W-1:0] a_rows, inner_size, b_cols;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [IDX_W-1:0] i, i_next, j, j_next, m, m_next;
  logic             accept;
  req_t             req;
  logic [DIM_W-1:0] rlim, clim;
  logic             in_range;
  logic             k_end, j_end, i_end;

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= 4'd8;
      inner_size <= 4'd8;
      b_cols     <= 4'd8;
    end else if (wr_en) begin
      case (wr_index)
        REG_A_ROWS:     a_rows     <= wr_data;
        REG_INNER_SIZE: inner_size <= wr_data;
        REG_B_COLS:     b_cols     <= wr_data;
        default:        ;
      endcase
    end
  end

  assign nr = eff_dim(a_rows, MAX_D);
  assign nk = eff_dim(inner_size, MAX_D);
  assign nc = eff_dim(b_cols, MAX_D);

  // request decode and bounds check
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign req    = req_t'(req_type);
  assign rlim   = (req == REQ_WR_B) ? nk : nr;
  assign clim   = (req == REQ_WR_A) ? nk : nc;
  assign in_range = ({1'b0, row} < rlim) && ({1'b0, col} < clim);

  // loop ends
  assign k_end = ({1'b0, m} == nk - DIM_W'(1));
  assign j_end = ({1'b0, j} == nc - DIM_W'(1));
  assign i_end = ({1'b0, i} == nr - DIM_W'(1));

  // state register and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      m     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      m     <= m_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && req == REQ_COMPUTE) state_next = S_ISSUE;
      S_ISSUE: if (k_end && j_end && i_end) state_next = S_DRAIN;
      S_DRAIN: if (run_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // loop counters, inner index fastest
  always_comb begin
    i_next = i;
    j_next = j;
    m_next = m;
    if (state == S_IDLE) begin
      i_next = '0;
      j_next = '0;
      m_next = '0;
    end else if (state == S_ISSUE) begin
      if (!k_end) begin
        m_next = m + IDX_W'(1);
      end else begin
        m_next = '0;
        if (!j_end) begin
          j_next = j + IDX_W'(1);
        end else begin
          j_next = '0;
          i_next = i + IDX_W'(1);
        end
      end
    end
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.sel = req;
    cmd.ack_status = ST_OK;
    case (state)
      S_IDLE: begin
        cmd.row = row;
        cmd.col = col;
        if (accept && req != REQ_COMPUTE) begin
          cmd.ack        = 1'b1;
          cmd.wr_en      = in_range;
          cmd.ack_status = in_range ? ST_OK : ST_RANGE;
        end
      end
      S_ISSUE: begin
        cmd.mac       = 1'b1;
        cmd.row       = i;
        cmd.col       = j;
        cmd.kk        = m;
        cmd.first     = (m == '0);
        cmd.last_k    = k_end;
        cmd.last_elem = k_end && j_end && i_end;
      end
      default: ;
    endcase
  end

endmodule

### hdl/mma_dp.sv
// ----------------------------------------------------------------------------
// mma_dp
// operand stores, multiply pipeline, saturating accumulator and result word
// ----------------------------------------------------------------------------
module mma_dp import mma_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mma_cmd_t                cmd,
  input  logic signed [VAL_W-1:0] value,
  output logic                    run_done,
  output logic                    strobe,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output status_t                 status,
  output logic                    last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  function automatic logic [AW-1:0] entry_addr(logic [IDX_W-1:0] r,
                                               logic [IDX_W-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [DEPTH];
  logic signed [VAL_W-1:0] c_mem [DEPTH];
  logic [DEPTH-1:0]        c_vld;

  logic [AW-1:0] wr_addr, a_rd, b_rd, res_addr;
  logic signed [VAL_W-1:0] a_q, b_q, c_q;
  logic                    cv_q;

  logic                    s1_vld, s1_first, s1_lastk, s1_lastel;
  logic [IDX_W-1:0]        s1_row, s1_col;
  logic                    s2_vld, s2_first, s2_lastk, s2_lastel;
  logic [IDX_W-1:0]        s2_row, s2_col;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0] s2_c;

  logic signed [VAL_W-1:0] acc, base, res_val;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0] sum;
  logic                    res_wr;

  // addresses
  assign wr_addr  = entry_addr(cmd.row, cmd.col);
  assign a_rd     = entry_addr(cmd.row, cmd.kk);
  assign b_rd     = entry_addr(cmd.kk, cmd.col);
  assign res_addr = entry_addr(s2_row, s2_col);

  // store A
  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.sel == REQ_WR_A) begin
      a_mem[wr_addr] <= value;
    end
    a_q <= a_mem[a_rd];
  end

  // store B
  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.sel == REQ_WR_B) begin
      b_mem[wr_addr] <= value;
    end
    b_q <= b_mem[b_rd];
  end

  // accumulator store C, written by loads and by finished results
  always_ff @(posedge clk) begin
    if (res_wr) begin
      c_mem[res_addr] <= res_val;
    end else if (cmd.wr_en && cmd.sel == REQ_WR_C) begin
      c_mem[wr_addr] <= value;
    end
    c_q <= c_mem[wr_addr];
  end

  // written marks for C, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= '0;
      cv_q  <= 1'b0;
    end else begin
      cv_q <= c_vld[wr_addr];
      if (res_wr) begin
        c_vld[res_addr] <= 1'b1;
      end else if (cmd.wr_en && cmd.sel == REQ_WR_C) begin
        c_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.mac;
      s2_vld <= s1_vld;
    end
  end

  // pipeline payload: operand read, then product
  always_ff @(posedge clk) begin
    s1_first  <= cmd.first;
    s1_lastk  <= cmd.last_k;
    s1_lastel <= cmd.last_elem;
    s1_row    <= cmd.row;
    s1_col    <= cmd.col;
    s2_first  <= s1_first;
    s2_lastk  <= s1_lastk;
    s2_lastel <= s1_lastel;
    s2_row    <= s1_row;
    s2_col    <= s1_col;
    s2_c      <= cv_q ? c_q : '0;
    prod      <= a_q * b_q;
  end

  // floor the product, add and saturate
  assign base    = s2_first ? s2_c : acc;
  assign prod_sh = prod >>> FRAC_BITS;
  assign sum     = SUM_W'(prod_sh) + SUM_W'(base);
  always_comb begin
    if (sum > SAT_HI) begin
      res_val = VAL_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      res_val = VAL_W'(SAT_LO);
    end else begin
      res_val = VAL_W'(sum);
    end
  end
  assign res_wr   = s2_vld && s2_lastk;
  assign run_done = res_wr && s2_lastel;

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      acc <= res_val;
    end
  end

  // result word strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.ack || res_wr;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (cmd.ack) begin
      out_row   <= cmd.row;
      out_col   <= cmd.col;
      out_value <= '0;
      status    <= cmd.ack_status;
      last      <= 1'b1;
    end else if (res_wr) begin
      out_row   <= s2_row;
      out_col   <= s2_col;
      out_value <= res_val;
      status    <= ST_RESULT;
      last      <= s2_lastel;
    end
  end

endmodule

### hdl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix multiply-accumulate
// loads A, B and C entries, then computes C += A*B in signed fixed point
//
//   channel  handshake            payload
//   request  start / busy         req_type row col value
//   result   strobe (no stall)    out_row out_col out_value status last
//   config   wr_en                wr_index wr_data
//
// an entry write is taken when start is high and busy low, and acknowledged
// the cycle after; writes may follow back to back.
// a compute request runs on the single multiply-accumulate unit through its
// operand-read and product registers; busy is high until the cycle that
// carries the final result.
// reset clears the dimension registers to 8 and marks all of C as zero.
// results are shown for one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type,
  input  logic [IDX_W-1:0]        row,
  input  logic [IDX_W-1:0]        col,
  input  logic signed [VAL_W-1:0] value,
  output logic                    strobe,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic [1:0]              status,
  output logic                    last,
  input  logic                    wr_en,
  input  logic [REG_IDX_W-1:0]    wr_index,
  input  logic [DIM_W-1:0]        wr_data
);

  `include "matrix_multiply_accumulate_assert.svh"

  mma_cmd_t cmd;
  logic     run_done;
  status_t  status_e;

  // controller
  mma_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .row      (row),
    .col      (col),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .run_done (run_done),
    .busy     (busy),
    .cmd      (cmd)
  );

  // datapath
  mma_dp #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .run_done  (run_done),
    .strobe    (strobe),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .status    (status_e),
    .last      (last)
  );

  assign status = status_e;

  // checks
  `MMA_ASSERT_NEXT(a_write_ack, start && !busy && req_type != REQ_COMPUTE,
    strobe && last && status != ST_RESULT, "write word not acknowledged")
  `MMA_ASSERT_NEXT(a_run_busy, start && !busy && req_type == REQ_COMPUTE,
    busy && !strobe, "compute request did not raise busy")
  `MMA_ASSERT_NOW(a_busy_end, $fell(busy),
    strobe && last && status == ST_RESULT, "busy fell without final result")
  `MMA_ASSERT_NOW(a_mid_result, strobe && status == ST_RESULT && !last,
    busy, "result word outside a compute run")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix multiply-accumulate testbench
// drives entry writes and compute requests through start/busy, predicts every
// acknowledgement and C entry in fixed point with its own copy of the stores,
// and checks each strobed word against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module testbench import mma_pkg::*; ();

  localparam int SIDE       = 8;
  localparam int FRAC       = 16;
  localparam int QUIET_MAX  = 2000;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  // one word as it leaves the block
  typedef struct {
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
    status_t                 st;
    logic                    lst;
  } word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              req_type = '0;
  logic [IDX_W-1:0]        row = '0;
  logic [IDX_W-1:0]        col = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    strobe;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic [1:0]              status;
  logic                    last;
  logic                    wr_en = 1'b0;
  logic [REG_IDX_W-1:0]    wr_index = '0;
  logic [DIM_W-1:0]        wr_data = '0;

  // shadow of the block's registers and stores
  logic [DIM_W-1:0]        reg_a_rows = 4'd8;
  logic [DIM_W-1:0]        reg_inner  = 4'd8;
  logic [DIM_W-1:0]        reg_b_cols = 4'd8;
  logic signed [VAL_W-1:0] a_mem [SIDE*SIDE];
  logic signed [VAL_W-1:0] b_mem [SIDE*SIDE];
  logic signed [VAL_W-1:0] c_mem [SIDE*SIDE];
  bit                      a_set [SIDE*SIDE];
  bit                      b_set [SIDE*SIDE];

  word_t owed_words[$];
  int    faults = 0;
  int    quiet = 0;
  bit    steady = 1'b0;

  matrix_multiply_accumulate uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .row(row), .col(col), .value(value),
    .strobe(strobe), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .status(status), .last(last),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // register value to working size: zero means one, clamp at the maximum
  function automatic int span(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > SIDE) return SIDE;
    return int'(d);
  endfunction

  // mix of extremes, full-range and small fixed-point values
  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      1, 2: v = $urandom;
      default: v = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
    return v;
  endfunction

  // mostly small sizes, now and then the extremes and the clamped codes
  function automatic logic [DIM_W-1:0] pick_dim();
    logic [DIM_W-1:0] d;
    if ($urandom_range(0, 9) < 7) begin
      d = DIM_W'($urandom_range(1, 3));
    end else begin
      case ($urandom_range(0, 3))
        0: d = 4'd0;
        1: d = 4'd8;
        2: d = 4'd9;
        default: d = 4'd15;
      endcase
    end
    return d;
  endfunction

  // store update or C += A*B, queueing the words the block owes
  task automatic gemm_update(input req_t req, input logic [IDX_W-1:0] r, c,
                             input logic signed [VAL_W-1:0] v);
    int nr, nk, nc, rlim, clim;
    logic signed [63:0] acc, ea, eb, prod;
    word_t w;
    nr = span(reg_a_rows);
    nk = span(reg_inner);
    nc = span(reg_b_cols);
    if (req == REQ_COMPUTE) begin
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          acc = c_mem[i*SIDE+j];
          for (int m = 0; m < nk; m++) begin
            ea = a_mem[i*SIDE+m];
            eb = b_mem[m*SIDE+j];
            prod = ea * eb;
            acc = acc + (prod >>> FRAC);
            if (acc > SAT_HI) acc = SAT_HI;
            if (acc < SAT_LO) acc = SAT_LO;
          end
          c_mem[i*SIDE+j] = acc[VAL_W-1:0];
          w.r = IDX_W'(i);
          w.c = IDX_W'(j);
          w.v = acc[VAL_W-1:0];
          w.st = ST_RESULT;
          w.lst = (i == nr - 1) && (j == nc - 1);
          owed_words.push_back(w);
        end
      end
    end else begin
      rlim = (req == REQ_WR_B) ? nk : nr;
      clim = (req == REQ_WR_A) ? nk : nc;
      w.r = r;
      w.c = c;
      w.v = '0;
      w.lst = 1'b1;
      if (int'(r) >= rlim || int'(c) >= clim) begin
        w.st = ST_RANGE;
      end else begin
        w.st = ST_OK;
        case (req)
          REQ_WR_A: begin
            a_mem[r*SIDE+c] = v;
            a_set[r*SIDE+c] = 1'b1;
          end
          REQ_WR_B: begin
            b_mem[r*SIDE+c] = v;
            b_set[r*SIDE+c] = 1'b1;
          end
          default: c_mem[r*SIDE+c] = v;
        endcase
      end
      owed_words.push_back(w);
    end
  endtask

  // present one word, idling first at random unless steady, and wait for it to be taken
  task automatic send_word(input req_t req, input logic [IDX_W-1:0] r, c,
                           input logic signed [VAL_W-1:0] v);
    if (!steady) begin
      while ($urandom_range(0, 99) < 23) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start    <= 1'b1;
    req_type <= req;
    row      <= r;
    col      <= c;
    value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    gemm_update(req, r, c, v);
  endtask

  // drop start and let every owed word come back
  task automatic wait_idle();
    start <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  // new sizes, written only once the block has gone quiet
  task automatic set_dims(input logic [DIM_W-1:0] na, nk, nc);
    wait_idle();
    write_reg(REG_A_ROWS, na);
    write_reg(REG_INNER_SIZE, nk);
    write_reg(REG_B_COLS, nc);
    wr_en <= 1'b0;
    reg_a_rows = na;
    reg_inner  = nk;
    reg_b_cols = nc;
  endtask

  // load any operand the next compute would read but nobody has written
  task automatic fill_operands();
    int nr, nk, nc;
    nr = span(reg_a_rows);
    nk = span(reg_inner);
    nc = span(reg_b_cols);
    for (int i = 0; i < nr; i++)
      for (int m = 0; m < nk; m++)
        if (!a_set[i*SIDE+m]) send_word(REQ_WR_A, IDX_W'(i), IDX_W'(m), rand_value());
    for (int m = 0; m < nk; m++)
      for (int j = 0; j < nc; j++)
        if (!b_set[m*SIDE+j]) send_word(REQ_WR_B, IDX_W'(m), IDX_W'(j), rand_value());
  endtask

  task automatic compute_now();
    fill_operands();
    send_word(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  // writes of each kind at the reset sizes, index and value extremes
  task automatic test_reset_writes();
    send_word(REQ_WR_A, 3'd7, 3'd7, 32'h7fff_ffff);
    send_word(REQ_WR_B, 3'd0, 3'd7, 32'h8000_0000);
    send_word(REQ_WR_C, 3'd7, 3'd0, 32'hffff_ffff);
    send_word(REQ_WR_C, 3'd0, 3'd0, 32'h0000_0000);
  endtask

  // zero acts as one, codes above eight act as eight, range rejects
  task automatic test_dim_clamp();
    set_dims(4'd0, 4'd15, 4'd9);
    send_word(REQ_WR_A, 3'd1, 3'd0, 32'h1234_5678);
    send_word(REQ_WR_A, 3'd0, 3'd7, 32'h0001_0000);
    send_word(REQ_WR_B, 3'd7, 3'd7, 32'hfffe_0000);
    send_word(REQ_WR_C, 3'd0, 3'd7, 32'h0000_8000);
    send_word(REQ_WR_C, 3'd1, 3'd0, 32'h7fff_ffff);
  endtask

  // saturation both ways and flooring of a tiny negative product
  task automatic test_saturation();
    set_dims(4'd1, 4'd1, 4'd2);
    send_word(REQ_WR_C, 3'd0, 3'd0, 32'h7fff_0000);
    send_word(REQ_WR_C, 3'd0, 3'd1, 32'h8001_0000);
    send_word(REQ_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_word(REQ_WR_B, 3'd0, 3'd0, 32'h0002_0000);
    send_word(REQ_WR_B, 3'd0, 3'd1, 32'hfffe_0000);
    send_word(REQ_COMPUTE, 3'd0, 3'd0, 32'h0);
    send_word(REQ_WR_A, 3'd0, 3'd0, 32'hffff_ffff);
    send_word(REQ_WR_B, 3'd0, 3'd0, 32'h0000_0001);
    send_word(REQ_WR_B, 3'd0, 3'd1, 32'h0001_0000);
    send_word(REQ_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
  endtask

  // one compute over the largest matrices, loads sent back to back
  task automatic test_full_size();
    set_dims(4'd8, 4'd8, 4'd8);
    steady = 1'b1;
    compute_now();
    steady = 1'b0;
  endtask

  // phases of random sizes with random writes and computes
  task automatic test_random();
    req_t req;
    logic [IDX_W-1:0] r, c;
    for (int ph = 0; ph < 5; ph++) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      for (int n = 0; n < 3; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          compute_now();
        end else begin
          req = req_t'($urandom_range(0, 2));
          r = IDX_W'($urandom);
          c = IDX_W'($urandom);
          // keep most indices inside the target matrix
          if ($urandom_range(0, 4) != 0) begin
            r = IDX_W'($urandom_range(0, span(req == REQ_WR_B ? reg_inner : reg_a_rows) - 1));
            c = IDX_W'($urandom_range(0, span(req == REQ_WR_A ? reg_inner : reg_b_cols) - 1));
          end
          send_word(req, r, c, rand_value());
        end
      end
      compute_now();
    end
  endtask

  // compare each strobed word with the oldest owed one
  always @(posedge clk) begin
    word_t w;
    if (!rst && strobe) begin
      if (owed_words.size() == 0) begin
        $error("unexpected word: row %0d col %0d value %0h status %0d",
               out_row, out_col, out_value, status);
        faults++;
      end else begin
        w = owed_words.pop_front();
        if (out_row !== w.r) begin
          $error("out_row: expected %0d, got %0d", w.r, out_row);
          faults++;
        end
        if (out_col !== w.c) begin
          $error("out_col: expected %0d, got %0d", w.c, out_col);
          faults++;
        end
        if (out_value !== w.v) begin
          $error("out_value: expected %08h, got %08h", w.v, out_value);
          faults++;
        end
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status);
          faults++;
        end
        if (last !== w.lst) begin
          $error("last: expected %0d, got %0d", w.lst, last);
          faults++;
        end
      end
    end
  end

  // give up once nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_MAX) begin
        $error("stalled with %0d words still owed", owed_words.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (c_mem[i]) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
      c_mem[i] = '0;
      a_set[i] = 1'b0;
      b_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_writes();
    test_dim_clamp();
    test_saturation();
    test_full_size();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
